/* hw/rtl/mdvr_pkg.sv */
// Shared types, constants and helpers for the multicast distance-vector router.
package mdvr_pkg;

    localparam int NUM_NODES = 10;
    localparam int MASK_W    = 10;
    localparam int ID_W      = 4;
    localparam int COST_W    = 4;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 10;

    localparam logic [COST_W-1:0] INF_COST = COST_W'(10);
    localparam logic [ID_W-1:0]   NONE_ID  = ID_W'(10);

    typedef enum logic [CMD_W-1:0] {
        CMD_DV      = 2'd0,
        CMD_DATA    = 2'd1,
        CMD_JOIN    = 2'd2,
        CMD_INSTALL = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROUTER_ID = 1'd0,
        CFG_ATTACHED  = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        t_cmd              cmd;
        logic [ID_W-1:0]   arrival_lan;
        logic [ID_W-1:0]   sender_lan;
        logic [ID_W-1:0]   sender_router;
        logic [ID_W-1:0]   dest;
        logic [COST_W-1:0] adv_cost;
        logic [ID_W-1:0]   adv_next_router;
    } t_item;

    typedef struct packed {
        logic [MASK_W-1:0] forward_mask;
        logic [COST_W-1:0] route_cost;
        logic [ID_W-1:0]   route_next_lan;
        logic [ID_W-1:0]   route_next_router;
        logic [MASK_W-1:0] child_lans;
    } t_result;

    // One-hot bit of a LAN; LANs outside the table map to no bit.
    function automatic logic [MASK_W-1:0] lan_bit(input logic [ID_W-1:0] lan);
        logic [MASK_W-1:0] bits;
        bits = '0;
        for (int k = 0; k < MASK_W; k++) begin
            if (k < NUM_NODES && lan == ID_W'(k)) begin
                bits[k] = 1'b1;
            end
        end
        return bits;
    endfunction

endpackage

/* hw/rtl/mdvr_item_if.sv */
// Input channel: valid/ready handshake with one router command item.
interface mdvr_item_if;
    logic                             valid;
    logic                             ready;
    logic [mdvr_pkg::CMD_W-1:0]       cmd;
    logic [mdvr_pkg::ID_W-1:0]        arrival_lan;
    logic [mdvr_pkg::ID_W-1:0]        sender_lan;
    logic [mdvr_pkg::ID_W-1:0]        sender_router;
    logic [mdvr_pkg::ID_W-1:0]        dest;
    logic [mdvr_pkg::COST_W-1:0]      adv_cost;
    logic [mdvr_pkg::ID_W-1:0]        adv_next_router;

    modport source (
        output valid, cmd, arrival_lan, sender_lan, sender_router, dest, adv_cost,
               adv_next_router,
        input  ready
    );
    modport sink (
        input  valid, cmd, arrival_lan, sender_lan, sender_router, dest, adv_cost,
               adv_next_router,
        output ready
    );
endinterface

/* hw/rtl/mdvr_result_if.sv */
// Output channel: valid/ready handshake with one route result item.
interface mdvr_result_if;
    logic                            valid;
    logic                            ready;
    logic [mdvr_pkg::MASK_W-1:0]     forward_mask;
    logic [mdvr_pkg::COST_W-1:0]     route_cost;
    logic [mdvr_pkg::ID_W-1:0]       route_next_lan;
    logic [mdvr_pkg::ID_W-1:0]       route_next_router;
    logic [mdvr_pkg::MASK_W-1:0]     child_lans;

    modport source (
        output valid, forward_mask, route_cost, route_next_lan, route_next_router,
               child_lans,
        input  ready
    );
    modport sink (
        input  valid, forward_mask, route_cost, route_next_lan, route_next_router,
               child_lans,
        output ready
    );
endinterface

/* hw/rtl/mdvr_route_table.sv */
// Route table storage with the per-command update and forwarding logic.
module mdvr_route_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  mdvr_pkg::t_item               i_item,
    input  logic [mdvr_pkg::ID_W-1:0]     i_router_id,
    input  logic [mdvr_pkg::MASK_W-1:0]   i_attached,
    output mdvr_pkg::t_result             o_result
);

    logic [mdvr_pkg::COST_W-1:0] r_cost   [mdvr_pkg::NUM_NODES];
    logic [mdvr_pkg::ID_W-1:0]   r_nlan   [mdvr_pkg::NUM_NODES];
    logic [mdvr_pkg::ID_W-1:0]   r_nrtr   [mdvr_pkg::NUM_NODES];
    logic [mdvr_pkg::MASK_W-1:0] r_child  [mdvr_pkg::NUM_NODES];
    logic [mdvr_pkg::MASK_W-1:0] r_rx;

    logic [mdvr_pkg::COST_W-1:0] n_cost   [mdvr_pkg::NUM_NODES];
    logic [mdvr_pkg::ID_W-1:0]   n_nlan   [mdvr_pkg::NUM_NODES];
    logic [mdvr_pkg::ID_W-1:0]   n_nrtr   [mdvr_pkg::NUM_NODES];
    logic [mdvr_pkg::MASK_W-1:0] n_child  [mdvr_pkg::NUM_NODES];
    logic [mdvr_pkg::MASK_W-1:0] n_rx;

    logic                        dst_ok;
    logic [mdvr_pkg::COST_W-1:0] acost;
    logic [mdvr_pkg::COST_W-1:0] newc;
    logic [mdvr_pkg::ID_W-1:0]   cur_nlan;
    logic [mdvr_pkg::MASK_W-1:0] cur_child;
    logic [mdvr_pkg::MASK_W-1:0] abit;
    logic [mdvr_pkg::MASK_W-1:0] fwd;

    assign dst_ok = i_item.dest < mdvr_pkg::ID_W'(mdvr_pkg::NUM_NODES);
    // Clamp advertised cost to unreachable.
    assign acost  = (i_item.adv_cost > mdvr_pkg::INF_COST) ? mdvr_pkg::INF_COST
                                                           : i_item.adv_cost;
    assign newc   = acost + mdvr_pkg::COST_W'(1);
    assign abit   = mdvr_pkg::lan_bit(i_item.arrival_lan);

    always_comb begin
        cur_nlan  = mdvr_pkg::NONE_ID;
        cur_child = '0;
        for (int j = 0; j < mdvr_pkg::NUM_NODES; j++) begin
            if (i_item.dest == mdvr_pkg::ID_W'(j)) begin
                cur_nlan  = r_nlan[j];
                cur_child = r_child[j];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < mdvr_pkg::NUM_NODES; j++) begin
            n_cost[j]  = r_cost[j];
            n_nlan[j]  = r_nlan[j];
            n_nrtr[j]  = r_nrtr[j];
            n_child[j] = r_child[j];
        end
        n_rx = r_rx;
        fwd  = '0;
        unique case (i_item.cmd)
            mdvr_pkg::CMD_DV: begin
                for (int j = 0; j < mdvr_pkg::NUM_NODES; j++) begin
                    if (dst_ok && i_item.dest == mdvr_pkg::ID_W'(j)) begin
                        // Sender routes through us: mark its LAN as a child.
                        if (i_item.sender_router != i_router_id &&
                            i_item.adv_next_router == i_router_id) begin
                            n_child[j] = r_child[j] |
                                         mdvr_pkg::lan_bit(i_item.sender_lan);
                        end
                        if (newc < mdvr_pkg::INF_COST) begin
                            if (r_cost[j] > newc) begin
                                n_cost[j] = newc;
                                n_nlan[j] = i_item.sender_lan;
                                n_nrtr[j] = i_item.sender_router;
                            end else if (r_cost[j] == newc &&
                                         r_nrtr[j] > i_item.sender_router) begin
                                n_nlan[j] = i_item.sender_lan;
                                n_nrtr[j] = i_item.sender_router;
                            end
                        end
                    end
                end
            end
            mdvr_pkg::CMD_DATA: begin
                if (dst_ok && (abit & i_attached) != '0 &&
                    cur_nlan == i_item.arrival_lan) begin
                    fwd = i_attached & ~abit & (cur_child | r_rx);
                end
            end
            mdvr_pkg::CMD_JOIN: begin
                n_rx = r_rx | mdvr_pkg::lan_bit(i_item.sender_lan);
            end
            mdvr_pkg::CMD_INSTALL: begin
                for (int j = 0; j < mdvr_pkg::NUM_NODES; j++) begin
                    if ((i_attached & mdvr_pkg::lan_bit(mdvr_pkg::ID_W'(j))) != '0) begin
                        n_cost[j] = '0;
                        n_nlan[j] = mdvr_pkg::ID_W'(j);
                        n_nrtr[j] = i_router_id;
                    end
                end
            end
        endcase
    end

    always_comb begin
        o_result.forward_mask      = fwd;
        o_result.route_cost        = mdvr_pkg::INF_COST;
        o_result.route_next_lan    = mdvr_pkg::NONE_ID;
        o_result.route_next_router = mdvr_pkg::NONE_ID;
        o_result.child_lans        = '0;
        for (int j = 0; j < mdvr_pkg::NUM_NODES; j++) begin
            if (i_item.dest == mdvr_pkg::ID_W'(j)) begin
                o_result.route_cost        = n_cost[j];
                o_result.route_next_lan    = n_nlan[j];
                o_result.route_next_router = n_nrtr[j];
                o_result.child_lans        = n_child[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < mdvr_pkg::NUM_NODES; j++) begin
                r_cost[j]  <= mdvr_pkg::INF_COST;
                r_nlan[j]  <= mdvr_pkg::NONE_ID;
                r_nrtr[j]  <= mdvr_pkg::NONE_ID;
                r_child[j] <= '0;
            end
            r_rx <= '0;
        end else if (i_fire) begin
            for (int j = 0; j < mdvr_pkg::NUM_NODES; j++) begin
                r_cost[j]  <= n_cost[j];
                r_nlan[j]  <= n_nlan[j];
                r_nrtr[j]  <= n_nrtr[j];
                r_child[j] <= n_child[j];
            end
            r_rx <= n_rx;
        end
    end

endmodule

/* hw/rtl/multicast_distance_vector_router.sv */
// Top level of the multicast distance-vector router.
//
// Usage:
//   i_item carries one command per transaction: a distance-vector entry, a data
//   packet, a receiver join or an install of attached routes. o_result returns
//   exactly one result per command: the forward mask (data only) and the dest
//   route entry as it stands after the command.
//   Configuration (router id, attached LAN mask) is written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while no command is in flight.
// Timing:
//   A command is captured in an input register and resolved against the route
//   table once the result register is free or being taken; the result register
//   drives o_result. The table update is a single combinational pass, so one
//   command per cycle is sustained while o_result is taken.
// Reset:
//   Synchronous, active low. All routes become unreachable with no next hop,
//   child and receiver masks clear, configuration registers clear.
// Stall:
//   When o_result is not taken, the result register holds, the input register
//   holds its command, and i_item.ready drops once both are occupied.
module multicast_distance_vector_router (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mdvr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mdvr_pkg::CFG_W-1:0]          i_cfg_data,
    mdvr_item_if.sink                           i_item,
    mdvr_result_if.source                       o_result
);

    logic [mdvr_pkg::ID_W-1:0]   r_router_id;
    logic [mdvr_pkg::MASK_W-1:0] r_attached;

    logic              r_in_valid;
    mdvr_pkg::t_item   r_in;
    logic              r_out_valid;
    mdvr_pkg::t_result r_out;

    logic              accept;
    logic              advance;
    mdvr_pkg::t_result tbl_result;

    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;
    assign accept       = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_router_id <= '0;
            r_attached  <= '0;
        end else if (i_cfg_we) begin
            unique case (mdvr_pkg::t_cfg_idx'(i_cfg_idx))
                mdvr_pkg::CFG_ROUTER_ID: r_router_id <= i_cfg_data[mdvr_pkg::ID_W-1:0];
                mdvr_pkg::CFG_ATTACHED:  r_attached  <= i_cfg_data[mdvr_pkg::MASK_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the transaction payload and load the result register on advance; both hold while stalled.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.cmd             <= mdvr_pkg::t_cmd'(i_item.cmd);
            r_in.arrival_lan     <= i_item.arrival_lan;
            r_in.sender_lan      <= i_item.sender_lan;
            r_in.sender_router   <= i_item.sender_router;
            r_in.dest            <= i_item.dest;
            r_in.adv_cost        <= i_item.adv_cost;
            r_in.adv_next_router <= i_item.adv_next_router;
        end
        if (advance) begin
            r_out <= tbl_result;
        end
    end

    mdvr_route_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_item      (r_in),
        .i_router_id (r_router_id),
        .i_attached  (r_attached),
        .o_result    (tbl_result)
    );

    assign o_result.valid             = r_out_valid;
    assign o_result.forward_mask      = r_out.forward_mask;
    assign o_result.route_cost        = r_out.route_cost;
    assign o_result.route_next_lan    = r_out.route_next_lan;
    assign o_result.route_next_router = r_out.route_next_router;
    assign o_result.child_lans        = r_out.child_lans;

endmodule

/* verif/mdvr_tb_pkg.sv */
// Route table tracker that predicts and checks router results.
package mdvr_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import mdvr_pkg::*;

    class route_table_tracker;
        logic [COST_W-1:0] cost [NUM_NODES];
        logic [ID_W-1:0]   next_lan [NUM_NODES];
        logic [ID_W-1:0]   next_router [NUM_NODES];
        logic [MASK_W-1:0] children [NUM_NODES];
        logic [MASK_W-1:0] receivers;
        logic [ID_W-1:0]   own_id;
        logic [MASK_W-1:0] attached;
        t_result           expected_routes [$];
        int unsigned       errors;

        function new();
            for (int k = 0; k < NUM_NODES; k++) begin
                cost[k]        = INF_COST;
                next_lan[k]    = NONE_ID;
                next_router[k] = NONE_ID;
                children[k]    = '0;
            end
            receivers = '0;
            own_id    = '0;
            attached  = '0;
            errors    = 0;
        endfunction

        function logic [MASK_W-1:0] mask_of(logic [ID_W-1:0] lan);
            if (lan < NUM_NODES) begin
                return MASK_W'(1) << lan;
            end
            return '0;
        endfunction

        function void write_register(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_ROUTER_ID: own_id   = data[ID_W-1:0];
                CFG_ATTACHED:  attached = data[MASK_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the table by one accepted command and queue its result.
        function void note_command(t_item it);
            logic [COST_W:0]   hop_cost;
            logic [COST_W-1:0] capped;
            logic [MASK_W-1:0] arrival_bit;
            logic              in_table;
            t_result           res;
            int                j;
            in_table = (it.dest < NUM_NODES);
            capped   = (it.adv_cost > INF_COST) ? INF_COST : it.adv_cost;
            hop_cost = {1'b0, capped} + 1'b1;
            res.forward_mask = '0;
            case (it.cmd)
                CMD_DV: begin
                    if (in_table) begin
                        // mark the sender's LAN as a child only if it routes through us
                        if (it.sender_router != own_id && it.adv_next_router == own_id) begin
                            children[it.dest] |= mask_of(it.sender_lan);
                        end
                        if (hop_cost < INF_COST) begin
                            if (cost[it.dest] > hop_cost) begin
                                cost[it.dest]        = hop_cost[COST_W-1:0];
                                next_lan[it.dest]    = it.sender_lan;
                                next_router[it.dest] = it.sender_router;
                            end else if (cost[it.dest] == hop_cost &&
                                         next_router[it.dest] > it.sender_router) begin
                                next_lan[it.dest]    = it.sender_lan;
                                next_router[it.dest] = it.sender_router;
                            end
                        end
                    end
                end
                CMD_DATA: begin
                    arrival_bit = mask_of(it.arrival_lan);
                    if (in_table && (arrival_bit & attached) != '0 &&
                        next_lan[it.dest] == it.arrival_lan) begin
                        res.forward_mask = attached & ~arrival_bit &
                                           (children[it.dest] | receivers);
                    end
                end
                CMD_JOIN: begin
                    receivers |= mask_of(it.sender_lan);
                end
                default: begin
                    for (j = 0; j < NUM_NODES; j++) begin
                        if (attached[j]) begin
                            cost[j]        = '0;
                            next_lan[j]    = ID_W'(j);
                            next_router[j] = own_id;
                        end
                    end
                end
            endcase
            if (in_table) begin
                res.route_cost        = cost[it.dest];
                res.route_next_lan    = next_lan[it.dest];
                res.route_next_router = next_router[it.dest];
                res.child_lans        = children[it.dest];
            end else begin
                res.route_cost        = INF_COST;
                res.route_next_lan    = NONE_ID;
                res.route_next_router = NONE_ID;
                res.child_lans        = '0;
            end
            expected_routes.push_back(res);
        endfunction

        function int pending();
            return expected_routes.size();
        endfunction

        function void check_field(string name, logic [MASK_W-1:0] want,
                                  logic [MASK_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void compare_result(t_result got);
            t_result want;
            if (expected_routes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual 0x%0h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_routes.pop_front();
            check_field("forward_mask", want.forward_mask, got.forward_mask);
            check_field("route_cost", MASK_W'(want.route_cost), MASK_W'(got.route_cost));
            check_field("route_next_lan", MASK_W'(want.route_next_lan),
                        MASK_W'(got.route_next_lan));
            check_field("route_next_router", MASK_W'(want.route_next_router),
                        MASK_W'(got.route_next_router));
            check_field("child_lans", want.child_lans, got.child_lans);
        endfunction
    endclass

endpackage

/* verif/tb_top.sv */
// Top-level testbench for the multicast distance-vector router.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mdvr_pkg::*;
    import mdvr_tb_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    t_cfg_idx           i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;

    mdvr_item_if   item_ch ();
    mdvr_result_if result_ch ();

    route_table_tracker sb = new();

    bit src_calm  = 1'b0;
    bit sink_calm = 1'b0;
    int sink_hold = 0;

    multicast_distance_vector_router DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 9);
        return $urandom_range(15, 40);
    endfunction

    // Result side backpressure, with calm stretches now and then.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) begin
            sink_calm = !sink_calm;
        end
        if (sink_hold > 0) begin
            result_ch.ready = 1'b0;
            sink_hold--;
        end else begin
            result_ch.ready = 1'b1;
            if (!sink_calm && $urandom_range(0, 99) < 25) begin
                sink_hold = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && result_ch.valid === 1'b1 && result_ch.ready) begin
            got.forward_mask      = result_ch.forward_mask;
            got.route_cost        = result_ch.route_cost;
            got.route_next_lan    = result_ch.route_next_lan;
            got.route_next_router = result_ch.route_next_router;
            got.child_lans        = result_ch.child_lans;
            sb.compare_result(got);
        end
    end

    function automatic t_item make_item(t_cmd cmd, int arr, int slan, int srtr, int dst,
                                        int acost, int anext);
        t_item it;
        it.cmd             = cmd;
        it.arrival_lan     = ID_W'(arr);
        it.sender_lan      = ID_W'(slan);
        it.sender_router   = ID_W'(srtr);
        it.dest            = ID_W'(dst);
        it.adv_cost        = COST_W'(acost);
        it.adv_next_router = ID_W'(anext);
        return it;
    endfunction

    function automatic logic [ID_W-1:0] pick_attached_lan();
        int lan;
        if (sb.attached == '0 || $urandom_range(0, 4) == 0) begin
            return ID_W'($urandom_range(0, 15));
        end
        lan = $urandom_range(0, NUM_NODES - 1);
        while (!sb.attached[lan]) begin
            lan = $urandom_range(0, NUM_NODES - 1);
        end
        return ID_W'(lan);
    endfunction

    // Mostly well-formed route traffic aimed at the live table, plus some noise.
    function automatic t_item random_command();
        t_item it;
        int    r;
        it = make_item(t_cmd'($urandom_range(0, 3)), $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return it;
        end
        it.dest = ($urandom_range(0, 19) == 0) ? ID_W'($urandom_range(10, 15))
                                               : ID_W'($urandom_range(0, NUM_NODES - 1));
        if (r < 50) begin
            it.cmd           = CMD_DV;
            it.adv_cost      = ($urandom_range(0, 1) == 0) ? COST_W'($urandom_range(0, 3))
                                                           : COST_W'($urandom_range(0, 10));
            it.sender_lan    = pick_attached_lan();
            it.sender_router = ($urandom_range(0, 19) == 0) ? ID_W'($urandom_range(10, 15))
                                                            : ID_W'($urandom_range(0, 9));
            it.adv_next_router = ($urandom_range(0, 99) < 40) ? sb.own_id
                                                              : ID_W'($urandom_range(0, 10));
        end else if (r < 80) begin
            it.cmd = CMD_DATA;
            if (it.dest < NUM_NODES && $urandom_range(0, 99) < 75) begin
                it.arrival_lan = sb.next_lan[it.dest];
            end
        end else if (r < 93) begin
            it.cmd        = CMD_JOIN;
            it.sender_lan = ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(10, 15))
                                                        : ID_W'($urandom_range(0, 9));
        end else begin
            it.cmd = CMD_INSTALL;
        end
        return it;
    endfunction

    task automatic send_command(t_item it);
        int gap;
        if ($urandom_range(0, 49) == 0) begin
            src_calm = !src_calm;
        end
        gap = src_calm ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            item_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        item_ch.valid           = 1'b1;
        item_ch.cmd             = it.cmd;
        item_ch.arrival_lan     = it.arrival_lan;
        item_ch.sender_lan      = it.sender_lan;
        item_ch.sender_router   = it.sender_router;
        item_ch.dest            = it.dest;
        item_ch.adv_cost        = it.adv_cost;
        item_ch.adv_next_router = it.adv_next_router;
        do begin
            @(posedge i_clk);
        end while (item_ch.ready !== 1'b1);
        sb.note_command(it);
    endtask

    task automatic end_stream();
        @(negedge i_clk);
        item_ch.valid = 1'b0;
    endtask

    // Wait for every pending result, then let the pipeline settle.
    task automatic drain();
        int waited;
        waited = 0;
        while (sb.pending() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.write_register(idx, data);
    endtask

    task automatic run_phase(int rid, int lans, int count);
        drain();
        write_register(CFG_ROUTER_ID, CFG_W'(rid));
        write_register(CFG_ATTACHED, CFG_W'(lans));
        repeat (count) send_command(random_command());
        end_stream();
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        i_cfg_we                = 1'b0;
        i_cfg_idx               = CFG_ROUTER_ID;
        i_cfg_data              = '0;
        item_ch.valid           = 1'b0;
        item_ch.cmd             = CMD_DV;
        item_ch.arrival_lan     = '0;
        item_ch.sender_lan      = '0;
        item_ch.sender_router   = '0;
        item_ch.dest            = '0;
        item_ch.adv_cost        = '0;
        item_ch.adv_next_router = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: router 3 on LANs 0, 1, 4, 5, 6, 7.
        write_register(CFG_ROUTER_ID, CFG_W'(3));
        write_register(CFG_ATTACHED, CFG_W'(10'h0F3));
        send_command(make_item(CMD_DATA, 0, 0, 0, 0, 0, 0));
        send_command(make_item(CMD_INSTALL, 0, 0, 0, 0, 0, 0));
        send_command(make_item(CMD_JOIN, 0, 5, 0, 1, 0, 0));
        send_command(make_item(CMD_JOIN, 0, 12, 0, 1, 0, 0));
        send_command(make_item(CMD_DV, 0, 4, 1, 2, 0, 3));
        // equal cost, lower router id takes over
        send_command(make_item(CMD_DV, 0, 6, 0, 2, 0, 10));
        // own advertisement: no child, tie does not win
        send_command(make_item(CMD_DV, 0, 7, 3, 2, 0, 3));
        // cost reaches unreachable: child only, route unchanged
        send_command(make_item(CMD_DV, 0, 1, 2, 2, 9, 3));
        send_command(make_item(CMD_DV, 0, 5, 2, 2, 15, 3));
        send_command(make_item(CMD_DV, 0, 5, 2, 12, 0, 3));
        // next LAN beyond the table is kept but never a child
        send_command(make_item(CMD_DV, 0, 13, 5, 3, 2, 3));
        send_command(make_item(CMD_DATA, 6, 0, 0, 2, 0, 0));
        send_command(make_item(CMD_DATA, 4, 0, 0, 2, 0, 0));
        send_command(make_item(CMD_DATA, 13, 0, 0, 3, 0, 0));
        send_command(make_item(CMD_DATA, 0, 0, 0, 15, 0, 0));
        send_command(make_item(CMD_DATA, 0, 0, 0, 0, 0, 0));
        send_command(make_item(CMD_DV, 0, 9, 9, 9, 0, 3));
        send_command(make_item(CMD_DV, 0, 0, 0, 0, 0, 3));
        send_command(make_item(CMD_INSTALL, 15, 15, 15, 15, 15, 15));
        send_command(make_item(CMD_DATA, 2, 0, 0, 2, 0, 0));
        send_command(make_item(CMD_DATA, 1, 0, 0, 1, 0, 0));
        end_stream();

        run_phase(0, 10'h3FF, 216);
        run_phase(9, 10'h000, 216);
        run_phase($urandom_range(0, 9), $urandom_range(0, 1023), 216);
        run_phase(9, 10'h3FF, 216);
        run_phase($urandom_range(0, 9), $urandom_range(0, 1023), 216);

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            if (sb.pending() != 0) begin
                $display("%0t: %0d results never arrived, expected 0x%0h", $time,
                         sb.pending(), sb.expected_routes[0]);
            end
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
